[src/transposition_table_probe_store_core_defines.svh]
// Assertion macros shared by the transposition table probe and store core.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_CORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TTPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("ttps assertion failed");
`define TTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ttps assertion failed");
`else
`define TTPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/ttps_pkg.sv]
// Types and constants of the transposition table probe and store core.
`timescale 1ns / 1ps
package ttps_pkg;

	localparam int unsigned INDEX_BITS = 16;
	localparam int unsigned SLOT_COUNT = 1 << INDEX_BITS;

	typedef logic [INDEX_BITS-1:0] slot_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_ALPHA = 2'd1,
		KIND_BETA  = 2'd2,
		KIND_EXACT = 2'd3
	} flag_t;

	typedef struct packed {
		logic              func;
		logic [63:0]       lookup_key;
		logic [7:0]        search_depth;
		logic signed [7:0] alpha_bound;
		logic signed [7:0] beta_bound;
		logic signed [7:0] store_value;
		logic [7:0]        store_move;
		logic [1:0]        store_flag;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic signed [7:0] bound_value;
		logic signed [7:0] entry_value;
		logic [1:0]        entry_flag;
		logic [7:0]        entry_depth;
		logic [7:0]        entry_move;
		logic              collision;
	} rsp_t;

	typedef struct packed {
		logic [63:0]       key;
		logic [7:0]        move;
		logic [7:0]        depth;
		flag_t             flag;
		logic signed [7:0] value;
	} entry_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} stat_t;

endpackage

[src/ttps_req_if.sv]
// Request channel: valid/ready handshake with the probe or store fields.
`timescale 1ns / 1ps
interface ttps_req_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic [63:0]       lookup_key;
	logic [7:0]        search_depth;
	logic signed [7:0] alpha_bound;
	logic signed [7:0] beta_bound;
	logic signed [7:0] store_value;
	logic [7:0]        store_move;
	logic [1:0]        store_flag;

	modport source (
		output valid, func, lookup_key, search_depth, alpha_bound, beta_bound,
			store_value, store_move, store_flag,
		input ready
	);
	modport sink (
		input valid, func, lookup_key, search_depth, alpha_bound, beta_bound,
			store_value, store_move, store_flag,
		output ready
	);
endinterface

[src/ttps_rsp_if.sv]
// Response channel: valid/ready handshake with the probe or store result.
`timescale 1ns / 1ps
interface ttps_rsp_if;
	logic              valid;
	logic              ready;
	logic              hit;
	logic signed [7:0] bound_value;
	logic signed [7:0] entry_value;
	logic [1:0]        entry_flag;
	logic [7:0]        entry_depth;
	logic [7:0]        entry_move;
	logic              collision;

	modport source (
		output valid, hit, bound_value, entry_value, entry_flag, entry_depth,
			entry_move, collision,
		input ready
	);
	modport sink (
		input valid, hit, bound_value, entry_value, entry_flag, entry_depth,
			entry_move, collision,
		output ready
	);
endinterface

[src/ttps_ctrl.sv]
// Controller state machine: clearing pass, request intake and result commit.
`timescale 1ns / 1ps
module ttps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  ttps_pkg::stat_t  stat,
	output ttps_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EVAL  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   rsp_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !rsp_valid_q || rsp_ready;

	assign cmd.clr_wr = (state_q == S_CLEAR);
	assign cmd.accept = (state_q == S_IDLE) && req_valid;
	assign cmd.commit = (state_q == S_EVAL) && out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_next = S_EVAL;
			end
			S_EVAL: begin
				if (out_free) state_next = S_IDLE;
			end
			default: begin
				state_next = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/ttps_dp.sv]
// Datapath: slot memory, clearing counter, probe evaluation and result register.
`timescale 1ns / 1ps
module ttps_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ttps_pkg::cmd_t  cmd,
	output ttps_pkg::stat_t stat,
	input  ttps_pkg::req_t  req_data,
	output ttps_pkg::rsp_t  rsp_data
);

	ttps_pkg::entry_t mem [ttps_pkg::SLOT_COUNT];
	ttps_pkg::entry_t rd_q;
	ttps_pkg::entry_t wr_entry;
	ttps_pkg::req_t   item_q;
	ttps_pkg::rsp_t   res_q;
	ttps_pkg::rsp_t   res_next;
	ttps_pkg::slot_t  clr_cnt_q;
	ttps_pkg::slot_t  item_slot;
	ttps_pkg::slot_t  req_slot;
	logic             key_match;
	logic             deep;
	logic             big;

	assign item_slot = item_q.lookup_key[ttps_pkg::INDEX_BITS-1:0];
	assign req_slot  = req_data.lookup_key[ttps_pkg::INDEX_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign stat.clr_last = &clr_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req_data;
		end
	end

	assign wr_entry.key   = item_q.lookup_key;
	assign wr_entry.move  = item_q.store_move;
	assign wr_entry.depth = item_q.search_depth;
	assign wr_entry.flag  = ttps_pkg::flag_t'(item_q.store_flag);
	assign wr_entry.value = item_q.store_value;

	// A store is written when its result commits, so a following request
	// always reads the updated slot.
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_cnt_q] <= '0;
		end else if (cmd.commit && item_q.func) begin
			mem[item_slot] <= wr_entry;
		end
		if (cmd.accept) begin
			rd_q <= mem[req_slot];
		end
	end

	assign key_match = (rd_q.key == item_q.lookup_key);
	assign deep      = (rd_q.depth >= item_q.search_depth);
	assign big       = ($signed(rd_q.value) > 8'sd1) || ($signed(rd_q.value) < -8'sd1);

	always_comb begin
		res_next = '0;
		if (item_q.func) begin
			res_next.collision = (rd_q.key != 64'd0) && !key_match;
		end else begin
			res_next.entry_value = rd_q.value;
			res_next.entry_flag  = rd_q.flag;
			res_next.entry_depth = rd_q.depth;
			res_next.entry_move  = rd_q.move;
			if (key_match) begin
				case (rd_q.flag)
					ttps_pkg::KIND_EXACT: begin
						res_next.hit = deep || big;
						// Raise to alpha, else lower to beta; alpha wins when both apply.
						if ($signed(rd_q.value) < $signed(item_q.alpha_bound)) begin
							res_next.bound_value = item_q.alpha_bound;
						end else if ($signed(item_q.beta_bound) < $signed(rd_q.value)) begin
							res_next.bound_value = item_q.beta_bound;
						end else begin
							res_next.bound_value = rd_q.value;
						end
					end
					ttps_pkg::KIND_ALPHA: begin
						res_next.hit = deep &&
							($signed(rd_q.value) <= $signed(item_q.alpha_bound));
						res_next.bound_value = item_q.alpha_bound;
					end
					ttps_pkg::KIND_BETA: begin
						res_next.hit = deep &&
							($signed(rd_q.value) >= $signed(item_q.beta_bound));
						res_next.bound_value = item_q.beta_bound;
					end
					default: begin
						res_next.hit = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_next;
		end
	end

	assign rsp_data = res_q;

endmodule

[src/transposition_table_probe_store_core.sv]
// Top level of the direct-mapped transposition table probe and store core.
//
//   channel  modport  carries
//   req      sink     func, lookup_key, search_depth, window bounds, store fields
//   rsp      source   hit, bound_value, entry fields, collision
//
// Each request reads the slot memory as it is accepted, then evaluates, writes a
// store back through the single write port and loads the result register.
// After reset a clearing pass zeroes all 2^INDEX_BITS slots (65536 at the
// default), one slot per cycle, with req.ready low throughout.
// The result register holds a finished response while the next request is
// accepted; a stalled rsp only holds the evaluation step until the register frees.
`timescale 1ns / 1ps
`include "transposition_table_probe_store_core_defines.svh"
module transposition_table_probe_store_core (
	input logic      clk,
	input logic      arst_n,
	ttps_req_if.sink req,
	ttps_rsp_if.source rsp
);

	ttps_pkg::cmd_t  cmd;
	ttps_pkg::stat_t stat;
	ttps_pkg::req_t  req_data;
	ttps_pkg::rsp_t  rsp_data;

	assign req_data.func         = req.func;
	assign req_data.lookup_key   = req.lookup_key;
	assign req_data.search_depth = req.search_depth;
	assign req_data.alpha_bound  = req.alpha_bound;
	assign req_data.beta_bound   = req.beta_bound;
	assign req_data.store_value  = req.store_value;
	assign req_data.store_move   = req.store_move;
	assign req_data.store_flag   = req.store_flag;

	ttps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ttps_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

	assign rsp.hit         = rsp_data.hit;
	assign rsp.bound_value = rsp_data.bound_value;
	assign rsp.entry_value = rsp_data.entry_value;
	assign rsp.entry_flag  = rsp_data.entry_flag;
	assign rsp.entry_depth = rsp_data.entry_depth;
	assign rsp.entry_move  = rsp_data.entry_move;
	assign rsp.collision   = rsp_data.collision;

	`TTPS_ASSERT_NEXT(a_one_request_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready)
	`TTPS_ASSERT_ALWAYS(a_no_accept_while_clearing, clk, arst_n, !(cmd.clr_wr && cmd.accept))
	`TTPS_ASSERT_ALWAYS(a_commit_needs_room, clk, arst_n, !cmd.commit || !rsp.valid || rsp.ready)
	`TTPS_ASSERT_ALWAYS(a_store_result_no_hit, clk, arst_n, !(rsp.valid && rsp.collision && rsp.hit))

endmodule
